// ----- design/dots_pkg.sv -----
// Package: request codes, payload structs and cell control types for the scheduler.
`timescale 1ns / 1ps
package dots_pkg;
	localparam logic [2:0] REQ_ADD      = 3'd0;
	localparam logic [2:0] REQ_POLL     = 3'd1;
	localparam logic [2:0] REQ_COMPLETE = 3'd2;
	localparam logic [2:0] REQ_SUSPEND  = 3'd3;
	localparam logic [2:0] REQ_RESUME   = 3'd4;
	localparam logic [2:0] REQ_KILL     = 3'd5;

	localparam logic [2:0] OC_DELAY   = 3'd1;
	localparam logic [2:0] OC_SUSPEND = 3'd2;
	localparam logic [2:0] OC_CLOSE   = 3'd3;
	localparam logic [2:0] OC_YIELD   = 3'd4;

	localparam logic [1:0] KIND_FREE     = 2'd0;
	localparam logic [1:0] KIND_PERIODIC = 2'd1;
	localparam logic [1:0] KIND_ONCE     = 2'd2;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [31:0] now;
		logic [3:0]  slot;
		logic [31:0] interval;
		logic        one_shot;
		logic [2:0]  outcome;
		logic [7:0]  delay_ticks;
		logic [15:0] next_state;
		logic        immediate;
	} req_t;

	typedef struct packed {
		logic        ok;
		logic [3:0]  out_slot;
		logic [31:0] run_count;
		logic [15:0] exec_state;
	} rsp_t;

	// Broadcast command to every list cell.
	typedef struct packed {
		logic        ins;     // insert key/tag into the sorted row
		logic        rem;     // remove entry whose tag matches
		logic [31:0] key;
		logic [7:0]  tag;
	} cell_cmd_t;
endpackage

// ----- design/dots_cell.sv -----
// One cell of the sorted deadline chain: holds a deadline key and slot tag.
`timescale 1ns / 1ps
module dots_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  dots_pkg::cell_cmd_t cmd,
	// neighbour towards the head (left) and towards the tail (right)
	input  logic                l_valid,
	input  logic                l_goes,   // left cell keeps its entry above new key
	input  logic [31:0]         l_key,
	input  logic [7:0]          l_tag,
	input  logic                l_hit,    // removal point is left of here
	input  logic                r_valid,
	input  logic [31:0]         r_key,
	input  logic [7:0]          r_tag,
	output logic                valid,
	output logic                goes,
	output logic [31:0]         key,
	output logic [7:0]          tag,
	output logic                hit
);
	import dots_pkg::*;

	logic        valid_q;
	logic [31:0] key_q;
	logic [7:0]  tag_q;

	// Stay when stored key is at or before the new key (ties keep first-in order).
	assign goes  = valid_q && (cmd.key >= key_q);
	assign hit   = l_hit || (valid_q && tag_q == cmd.tag);
	assign valid = valid_q;
	assign key   = key_q;
	assign tag   = tag_q;

	// Shift right on insert, left on remove.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.ins) begin
			if (!goes) begin
				// take the new key if the left cell stays, else shift in a valid left entry
				valid_q <= l_goes || l_valid || valid_q;
				if (l_goes) begin
					key_q <= cmd.key;
					tag_q <= cmd.tag;
				end else if (l_valid) begin
					key_q <= l_key;
					tag_q <= l_tag;
				end
			end
		end else if (cmd.rem && hit) begin
			valid_q <= r_valid;
			key_q   <= r_key;
			tag_q   <= r_tag;
		end
	end
endmodule

// ----- design/dots_chain.sv -----
// Row of sorting cells forming the deadline-ordered list.
`timescale 1ns / 1ps
module dots_chain #(
	parameter int SLOTS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dots_pkg::cell_cmd_t cmd,
	output logic                head_valid,
	output logic [31:0]         head_key,
	output logic [7:0]          head_tag,
	output logic                found
);
	import dots_pkg::*;

	logic              v [SLOTS+1];
	logic              g [SLOTS+1];
	logic [31:0]       k [SLOTS+1];
	logic [7:0]        t [SLOTS+1];
	logic              h [SLOTS+1];

	// Head boundary: the new key goes to cell 0 if it cannot stay behind anything.
	assign v[0] = 1'b0;
	assign g[0] = 1'b1;
	assign k[0] = '0;
	assign t[0] = '0;
	assign h[0] = 1'b0;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		logic              vo, go, ho;
		logic [31:0]       ko;
		logic [7:0]        to;
		logic              rv;
		logic [31:0]       rk;
		logic [7:0]        rt;
		if (i == SLOTS - 1) begin : g_tail
			assign rv = 1'b0;
			assign rk = '0;
			assign rt = '0;
		end else begin : g_mid
			assign rv = v[i+2];
			assign rk = k[i+2];
			assign rt = t[i+2];
		end
		dots_cell u_cell (
			.clk(clk), .arst_n(arst_n), .cmd(cmd),
			.l_valid(v[i]), .l_goes(g[i]), .l_key(k[i]), .l_tag(t[i]), .l_hit(h[i]),
			.r_valid(rv), .r_key(rk), .r_tag(rt),
			.valid(vo), .goes(go), .key(ko), .tag(to), .hit(ho)
		);
		assign v[i+1] = vo;
		assign g[i+1] = go;
		assign k[i+1] = ko;
		assign t[i+1] = to;
		assign h[i+1] = ho;
	end

	assign head_valid = v[1];
	assign head_key   = k[1];
	assign head_tag   = t[1];
	assign found      = h[SLOTS];
endmodule

// ----- design/deadline_ordered_task_scheduler.sv -----
// Top level: task slot store, request sequencer and sorted deadline chain.
// Sequence: a request is decoded in the cycle after acceptance and its result registered
// at the next edge into out_q; only one item is in work at a time.
// A new request is taken only after acceptance, the result register and the result
// handshake are all through; until then the input is not ready.
// Reset: arst_n clears every slot to free, empties the chain and drops any running task.
`timescale 1ns / 1ps
module deadline_ordered_task_scheduler #(
	parameter int SLOTS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  dots_pkg::req_t  in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output dots_pkg::rsp_t  out_data
);
	import dots_pkg::*;

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic [31:0] deadline_q  [SLOTS];
	logic [31:0] period_q    [SLOTS];
	logic [31:0] runs_q      [SLOTS];
	logic [15:0] rstate_q    [SLOTS];
	logic [1:0]  kind_q      [SLOTS];
	logic        susp_q      [SLOTS];
	logic        run_valid_q;
	logic [SW-1:0] run_slot_q;
	logic [1:0]  pend_q;

	logic        busy_q;
	req_t        req_q;
	logic        out_valid_q;
	rsp_t        out_q;

	cell_cmd_t   cmd;
	logic        head_valid, found;
	logic [31:0] head_key;
	logic [7:0]  head_tag;

	dots_chain #(.SLOTS(SLOTS)) u_chain (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.head_valid(head_valid), .head_key(head_key), .head_tag(head_tag), .found(found)
	);

	assign in_ready  = !busy_q && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Decode the held request against slot state.
	logic          free_any;
	logic [SW-1:0] free_idx;
	logic          slot_in;
	logic [SW-1:0] sidx;
	logic          slot_ok, is_per, is_run;
	logic [SW-1:0] hidx;
	logic          cl, sp;
	logic [1:0]    rkind;

	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (kind_q[i] == KIND_FREE) begin
				free_any = 1'b1;
				free_idx = SW'(i);
			end
		end
	end

	assign slot_in = 32'(req_q.slot) < SLOTS;
	assign sidx    = SW'(req_q.slot);
	assign slot_ok = slot_in && kind_q[sidx] != KIND_FREE;
	assign is_per  = slot_in && kind_q[sidx] == KIND_PERIODIC;
	assign is_run  = run_valid_q && run_slot_q == sidx;
	assign hidx    = SW'(head_tag);
	assign cl      = req_q.outcome == OC_CLOSE || pend_q[1];
	assign sp      = req_q.outcome == OC_SUSPEND || pend_q[0];
	assign rkind   = kind_q[run_slot_q];

	rsp_t        rsp;
	logic [31:0] rdl;

	always_comb begin
		cmd = '0;
		rsp = '0;
		rdl = '0;
		unique case (req_q.req_type)
			REQ_ADD: begin
				if (free_any) begin
					cmd.ins = 1'b1;
					cmd.key = req_q.now + req_q.interval;
					cmd.tag = 8'(free_idx);
					rsp.ok = 1'b1;
					rsp.out_slot = 4'(free_idx);
				end
			end
			REQ_POLL: begin
				if (!run_valid_q && head_valid && req_q.now >= head_key) begin
					cmd.rem = 1'b1;
					cmd.tag = head_tag;
					rsp.ok = 1'b1;
					rsp.out_slot = 4'(head_tag);
					rsp.run_count = runs_q[hidx];
					rsp.exec_state = rstate_q[hidx];
				end
			end
			REQ_COMPLETE: begin
				if (run_valid_q) begin
					rsp.ok = 1'b1;
					rsp.out_slot = 4'(run_slot_q);
					cmd.tag = 8'(run_slot_q);
					if (req_q.outcome == OC_DELAY)
						rdl = deadline_q[run_slot_q] + 32'(req_q.delay_ticks);
					else if (req_q.outcome == OC_YIELD)
						rdl = req_q.now;
					else
						rdl = deadline_q[run_slot_q] + period_q[run_slot_q];
					cmd.key = rdl;
					if (!cl && !(rkind == KIND_PERIODIC && sp) &&
					    (req_q.outcome == OC_DELAY || req_q.outcome == OC_YIELD ||
					     rkind == KIND_PERIODIC))
						cmd.ins = 1'b1;
				end
			end
			REQ_SUSPEND: begin
				if (is_per && (is_run || (!susp_q[sidx] && !is_run))) begin
					rsp.ok = 1'b1;
					cmd.rem = !is_run;
					cmd.tag = 8'(sidx);
				end
			end
			REQ_RESUME: begin
				if (is_per && susp_q[sidx]) begin
					rsp.ok = 1'b1;
					cmd.ins = 1'b1;
					cmd.tag = 8'(sidx);
					cmd.key = req_q.now + (req_q.immediate ? 32'd0 : period_q[sidx]);
				end
			end
			REQ_KILL: begin
				if (slot_ok && (is_run || !susp_q[sidx])) begin
					rsp.ok = 1'b1;
					cmd.rem = !is_run;
					cmd.tag = 8'(sidx);
				end
			end
			default: ;
		endcase
		if (!busy_q) cmd = '0;
	end

	// Sequencer: take one item, apply it next cycle, hold the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			run_valid_q <= 1'b0;
			run_slot_q  <= '0;
			pend_q      <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				kind_q[i] <= KIND_FREE;
				susp_q[i] <= 1'b0;
			end
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (in_valid && in_ready) begin
				req_q  <= in_data;
				busy_q <= 1'b1;
			end
			if (busy_q) begin
				busy_q      <= 1'b0;
				out_valid_q <= 1'b1;
				out_q       <= rsp;
				unique case (req_q.req_type)
					REQ_ADD: if (free_any) begin
						kind_q[free_idx]     <= req_q.one_shot ? KIND_ONCE : KIND_PERIODIC;
						period_q[free_idx]   <= req_q.interval;
						deadline_q[free_idx] <= req_q.now + req_q.interval;
						runs_q[free_idx]     <= '0;
						rstate_q[free_idx]   <= '0;
						susp_q[free_idx]     <= 1'b0;
					end
					REQ_POLL: if (rsp.ok) begin
						run_valid_q <= 1'b1;
						run_slot_q  <= hidx;
						pend_q      <= '0;
					end
					REQ_COMPLETE: if (run_valid_q) begin
						run_valid_q <= 1'b0;
						pend_q      <= '0;
						if (cl) begin
							kind_q[run_slot_q] <= KIND_FREE;
							susp_q[run_slot_q] <= 1'b0;
						end else if (rkind == KIND_PERIODIC && sp) begin
							susp_q[run_slot_q] <= 1'b1;
							if (req_q.outcome == OC_SUSPEND)
								rstate_q[run_slot_q] <= req_q.next_state;
						end else if (req_q.outcome == OC_DELAY ||
						             req_q.outcome == OC_YIELD) begin
							deadline_q[run_slot_q] <= rdl;
							rstate_q[run_slot_q]   <= req_q.next_state;
						end else if (rkind == KIND_PERIODIC) begin
							runs_q[run_slot_q]     <= runs_q[run_slot_q] + 32'd1;
							deadline_q[run_slot_q] <= rdl;
							rstate_q[run_slot_q]   <= '0;
						end else begin
							kind_q[run_slot_q] <= KIND_FREE;
						end
					end
					REQ_SUSPEND: if (rsp.ok) begin
						rstate_q[sidx] <= req_q.next_state;
						if (is_run) pend_q[0] <= 1'b1;
						else susp_q[sidx] <= 1'b1;
					end
					REQ_RESUME: if (rsp.ok) begin
						susp_q[sidx]     <= 1'b0;
						rstate_q[sidx]   <= req_q.next_state;
						deadline_q[sidx] <= cmd.key;
					end
					REQ_KILL: if (rsp.ok) begin
						if (is_run) pend_q[1] <= 1'b1;
						else kind_q[sidx] <= KIND_FREE;
					end
					default: ;
				endcase
			end
		end
	end

	// found is informational only for removal; tie it into nothing else.
	logic unused_found;
	assign unused_found = found;
endmodule

// ----- tb/sched_checker.sv -----
// Checker: watches both channels, predicts each scheduler result and compares in order.
`timescale 1ns / 1ps
module sched_checker
	import dots_pkg::*;
#(
	parameter int SLOTS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_ready,
	input  req_t in_data,
	input  logic out_valid,
	input  logic out_ready,
	input  rsp_t out_data,
	output int   fail_count,
	output int   pending,
	output int   dispatched,
	output int   granted
);
	localparam logic [1:0] HELD_SUSPEND = 2'b01;
	localparam logic [1:0] HELD_CLOSE   = 2'b10;

	// Shadow task table and deadline order
	logic [31:0] due [SLOTS];
	logic [31:0] per [SLOTS];
	logic [31:0] runs [SLOTS];
	logic [15:0] rstate [SLOTS];
	logic [1:0]  kind [SLOTS];
	bit          susp [SLOTS];
	int          order [SLOTS];
	int          len;
	bit          busy;
	int          cur;
	logic [1:0]  held;
	rsp_t        want_q [$];

	function automatic void wipe_task(int s);
		due[s] = '0;
		per[s] = '0;
		runs[s] = '0;
		rstate[s] = '0;
		kind[s] = KIND_FREE;
		susp[s] = 0;
	endfunction

	// Insert after every entry with an equal or earlier deadline
	function automatic void link_task(int s);
		int p;
		p = 0;
		while (p < len && due[s] >= due[order[p]])
			p++;
		for (int i = len; i > p; i--)
			order[i] = order[i - 1];
		order[p] = s;
		len++;
	endfunction

	function automatic void unlink_at(int p);
		for (int i = p; i + 1 < len; i++)
			order[i] = order[i + 1];
		len--;
	endfunction

	function automatic int find_at(int s);
		for (int p = 0; p < len; p++)
			if (order[p] == s)
				return p;
		return len;
	endfunction

	// Apply one request to the shadow table and return its result
	function automatic rsp_t schedule(req_t r);
		rsp_t o;
		int s, p, h;
		bit close, sus, live;
		o = '0;
		s = r.slot;
		live = kind[s] != KIND_FREE;
		case (r.req_type)
			REQ_ADD: begin
				for (int t = SLOTS - 1; t >= 0; t--) begin
					if (kind[t] == KIND_FREE) begin
						wipe_task(t);
						kind[t] = r.one_shot ? KIND_ONCE : KIND_PERIODIC;
						per[t] = r.interval;
						due[t] = r.now + r.interval;
						link_task(t);
						o.ok = 1;
						o.out_slot = t[3:0];
						break;
					end
				end
			end
			REQ_POLL: begin
				if (!busy && len > 0 && r.now >= due[order[0]]) begin
					h = order[0];
					unlink_at(0);
					busy = 1;
					cur = h;
					held = '0;
					o.ok = 1;
					o.out_slot = h[3:0];
					o.run_count = runs[h];
					o.exec_state = rstate[h];
				end
			end
			REQ_COMPLETE: begin
				if (busy) begin
					close = r.outcome == OC_CLOSE || held[1];
					sus = r.outcome == OC_SUSPEND || held[0];
					o.ok = 1;
					o.out_slot = cur[3:0];
					if (close) begin
						wipe_task(cur);
					end else if (kind[cur] == KIND_PERIODIC && sus) begin
						susp[cur] = 1;
						if (r.outcome == OC_SUSPEND)
							rstate[cur] = r.next_state;
					end else if (r.outcome == OC_DELAY || r.outcome == OC_YIELD) begin
						if (r.outcome == OC_DELAY)
							due[cur] = due[cur] + r.delay_ticks;
						else
							due[cur] = r.now;
						rstate[cur] = r.next_state;
						link_task(cur);
					end else if (kind[cur] == KIND_PERIODIC) begin
						runs[cur] = runs[cur] + 1;
						due[cur] = due[cur] + per[cur];
						rstate[cur] = '0;
						link_task(cur);
					end else begin
						wipe_task(cur);
					end
					busy = 0;
					held = '0;
				end
			end
			REQ_SUSPEND: begin
				if (live && kind[s] == KIND_PERIODIC) begin
					if (busy && cur == s) begin
						held = held | HELD_SUSPEND;
						rstate[s] = r.next_state;
						o.ok = 1;
					end else begin
						p = find_at(s);
						if (p < len) begin
							unlink_at(p);
							susp[s] = 1;
							rstate[s] = r.next_state;
							o.ok = 1;
						end
					end
				end
			end
			REQ_RESUME: begin
				if (live && kind[s] == KIND_PERIODIC && susp[s]) begin
					susp[s] = 0;
					rstate[s] = r.next_state;
					due[s] = r.now + (r.immediate ? 32'd0 : per[s]);
					link_task(s);
					o.ok = 1;
				end
			end
			REQ_KILL: begin
				if (live) begin
					if (busy && cur == s) begin
						held = held | HELD_CLOSE;
						o.ok = 1;
					end else begin
						p = find_at(s);
						if (p < len) begin
							unlink_at(p);
							wipe_task(s);
							o.ok = 1;
						end
					end
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	// Compare the oldest expectation first, then queue the new one
	always @(posedge clk or negedge arst_n) begin
		rsp_t w;
		if (!arst_n) begin
			for (int s = 0; s < SLOTS; s++) begin
				wipe_task(s);
				order[s] = 0;
			end
			len = 0;
			busy = 0;
			cur = 0;
			held = '0;
			want_q.delete();
			fail_count = 0;
			pending = 0;
			dispatched = 0;
			granted = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (want_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: unexpected result %h", $realtime, out_data);
				end else begin
					w = want_q.pop_front();
					if (out_data !== w) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: mismatch exp ok=%0d slot=%0d runs=%0d st=%h got ok=%0d slot=%0d runs=%0d st=%h",
								$realtime, w.ok, w.out_slot, w.run_count, w.exec_state,
								out_data.ok, out_data.out_slot, out_data.run_count,
								out_data.exec_state);
					end
				end
			end
			if (in_valid && in_ready) begin
				w = schedule(in_data);
				if (w.ok)
					granted++;
				if (w.ok && in_data.req_type == REQ_POLL)
					dispatched++;
				want_q.push_back(w);
			end
			pending = want_q.size();
		end
	end
endmodule

// ----- tb/tb_top.sv -----
// Testbench top: clock, reset, request stimulus, result draining and the verdict.
`timescale 1ns / 1ps
module tb_top;
	import dots_pkg::*;

	localparam logic [2:0] REQ_UNKNOWN_LO = 3'd6;
	localparam logic [2:0] REQ_UNKNOWN_HI = 3'd7;
	localparam logic [2:0] OC_NONE        = 3'd0;
	localparam logic [2:0] OC_ODD         = 3'd7;
	localparam int         PHASE_ITEMS    = 410;
	localparam int         HOLD_CYCLES    = 300;
	localparam int         WATCHDOG_LIMIT = 5000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	req_t in_data;
	logic out_valid;
	logic out_ready;
	rsp_t out_data;
	int   fail_count, pending, dispatched, granted;
	int   tx_idle_pct, rx_idle_pct;
	bit   hold_req;
	int   sent;
	int   quiet;
	logic [31:0] tick;

	deadline_ordered_task_scheduler dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	sched_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.fail_count(fail_count),
		.pending   (pending),
		.dispatched(dispatched),
		.granted   (granted)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Receiver: random stalls, or a long hold-off on request
	initial begin
		out_ready = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 0;
			end
			out_ready = $urandom_range(99) >= rx_idle_pct;
		end
	end

	// Watchdog: end the run if nothing moves for too long
	initial begin
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// Offer one item, with an optional gap first, and hold it until accepted
	task automatic offer(input req_t r);
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid = 0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid = 1;
		in_data = r;
		do
			@(posedge clk);
		while (!in_ready);
		sent++;
		@(negedge clk);
	endtask

	function automatic req_t blank(logic [2:0] kind);
		req_t r;
		r = '0;
		r.req_type = kind;
		r.now = tick;
		return r;
	endfunction

	// Random request, weighted towards well-formed add/poll/complete traffic
	function automatic req_t pick_request();
		req_t r;
		int w;
		r.now = '0;
		r.slot = 4'($urandom_range(15));
		r.one_shot = $urandom_range(3) == 0;
		r.delay_ticks = 8'($urandom);
		r.next_state = 16'($urandom);
		r.immediate = 1'($urandom_range(1));
		w = $urandom_range(99);
		if (w < 10)
			r.outcome = 3'($urandom_range(7));
		else if (w < 60)
			r.outcome = OC_NONE;
		else
			r.outcome = 3'($urandom_range(1, 4));
		w = $urandom_range(99);
		if (w < 85)
			r.interval = $urandom_range(0, 40);
		else if (w < 95)
			r.interval = $urandom;
		else
			r.interval = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
		tick = ($urandom_range(99) < 2) ? $urandom : tick + $urandom_range(0, 20);
		r.now = tick;
		w = $urandom_range(99);
		if (w < 20)
			r.req_type = REQ_ADD;
		else if (w < 50)
			r.req_type = REQ_POLL;
		else if (w < 74)
			r.req_type = REQ_COMPLETE;
		else if (w < 83)
			r.req_type = REQ_SUSPEND;
		else if (w < 91)
			r.req_type = REQ_RESUME;
		else if (w < 97)
			r.req_type = REQ_KILL;
		else
			r.req_type = $urandom_range(1) ? REQ_UNKNOWN_LO : REQ_UNKNOWN_HI;
		return r;
	endfunction

	// Stop offering until every result is back
	task automatic drain();
		in_valid = 0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		req_t r;
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		hold_req = 0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		sent = 0;
		tick = 32'd100;
		repeat (11) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: empty-table cases, extremes and the delay, none and undefined outcomes
		offer(blank(REQ_POLL));
		offer(blank(REQ_COMPLETE));
		offer(blank(REQ_UNKNOWN_LO));
		offer(blank(REQ_UNKNOWN_HI));
		r = blank(REQ_KILL); r.slot = 4'd15; offer(r);
		r = blank(REQ_ADD); r.interval = 32'hFFFF_FFFF; offer(r);
		r = blank(REQ_ADD); r.one_shot = 1; offer(r);
		r = blank(REQ_ADD); r.interval = 32'd0; offer(r);
		r = blank(REQ_SUSPEND); r.slot = 4'd14; offer(r);
		r = blank(REQ_SUSPEND); r.slot = 4'd13; r.next_state = 16'hFFFF; offer(r);
		r = blank(REQ_SUSPEND); r.slot = 4'd13; offer(r);
		r = blank(REQ_KILL); r.slot = 4'd13; offer(r);
		r = blank(REQ_RESUME); r.slot = 4'd13; r.immediate = 1; r.next_state = 16'hA5A5;
		offer(r);
		r = blank(REQ_RESUME); r.slot = 4'd14; offer(r);
		offer(blank(REQ_POLL));
		offer(blank(REQ_POLL));
		r = blank(REQ_SUSPEND); r.slot = 4'd13; offer(r);
		r = blank(REQ_KILL); r.slot = 4'd13; offer(r);
		r = blank(REQ_COMPLETE); r.outcome = OC_DELAY; r.delay_ticks = 8'hFF; offer(r);
		r = blank(REQ_POLL); r.now = 32'hFFFF_FFFF; offer(r);
		r = blank(REQ_COMPLETE); r.outcome = OC_ODD; offer(r);
		drain();

		// Phase 1: receiver mostly stalled, with one long hold-off to fill the pipe
		tx_idle_pct = 13;
		rx_idle_pct = 74;
		hold_req = 1;
		for (int i = 0; i < PHASE_ITEMS; i++)
			offer(pick_request());
		drain();

		// Phase 2: sender mostly idle
		tx_idle_pct = 74;
		rx_idle_pct = 13;
		for (int i = 0; i < PHASE_ITEMS; i++)
			offer(pick_request());
		drain();

		// Phase 3: full rate both ways
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		for (int i = 0; i < PHASE_ITEMS; i++)
			offer(pick_request());
		in_valid = 0;
		while (pending != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);

		$display("Sent %0d requests: %0d granted, %0d tasks dispatched, %0d failures.",
			sent, granted, dispatched, fail_count);
		$display("Phases covered sender gaps, receiver stalls, a long hold-off and full rate.");
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
